// ----- sv/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, register indexes and the control program of the greedy
// coin change core.
// ----------------------------------------------------------------------------
package gcc_pkg;

	// Register file layout and reset contents
	localparam int unsigned NUM_COINS_MAX = 6;
	localparam int unsigned COIN_W        = 16;
	localparam int unsigned CNT_W         = 16;
	localparam int unsigned IDX_W         = 3;

	localparam logic [IDX_W-1:0] REG_COIN_0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_DENOMS = 3'd6;

	localparam logic [IDX_W-1:0] DENOMS_RESET = 3'd6;

	localparam logic [NUM_COINS_MAX-1:0][COIN_W-1:0] COIN_RESET = {
		16'd100, 16'd50, 16'd25, 16'd10, 16'd5, 16'd1
	};

	// Output beat layout: index, count, total, zero fill to whole bytes
	localparam int unsigned OUT_BITS = IDX_W + CNT_W + CNT_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Sequencer step addresses
	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_DIV_INIT = 3'd1;
	localparam step_t STEP_DIV_STEP = 3'd2;
	localparam step_t STEP_WAIT_OUT = 3'd3;
	localparam step_t STEP_EMIT     = 3'd4;
	localparam step_t STEP_DONE     = 3'd5;

	// Jump conditions: taken means go to target, else fall to the next step
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_DIV_BUSY,
		COND_OUT_FULL,
		COND_MORE
	} cond_t;

	// One microcode word
	typedef struct packed {
		logic  in_ready;
		logic  div_init;
		logic  div_step;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctl_word_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic div_busy;
		logic out_full;
		logic more;
	} dp_status_t;

	// Control program
	function automatic ctl_word_t ucode_rom(input step_t step);
		ctl_word_t w;
		w = '{in_ready: 1'b0, div_init: 1'b0, div_step: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NO_INPUT;
				w.target   = STEP_IDLE;
			end
			STEP_DIV_INIT: begin
				w.div_init = 1'b1;
				w.cond     = COND_NEVER;
			end
			STEP_DIV_STEP: begin
				w.div_step = 1'b1;
				w.cond     = COND_DIV_BUSY;
				w.target   = STEP_DIV_STEP;
			end
			STEP_WAIT_OUT: begin
				w.cond   = COND_OUT_FULL;
				w.target = STEP_WAIT_OUT;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_MORE;
				w.target = STEP_DIV_INIT;
			end
			STEP_DONE: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- sv/gcc_seq.sv -----
// ----------------------------------------------------------------------------
// gcc_seq
// Step counter and control store; issues one control word per cycle and
// resolves conditional jumps from datapath flags.
// ----------------------------------------------------------------------------
module gcc_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  gcc_pkg::dp_status_t   status,
	output gcc_pkg::ctl_word_t    ctl
);

	gcc_pkg::step_t step_q;
	gcc_pkg::step_t step_d;
	logic           taken;

	// Fetch the current word
	assign ctl = gcc_pkg::ucode_rom(step_q);

	// Evaluate the jump condition
	always_comb begin
		unique case (ctl.cond)
			gcc_pkg::COND_NEVER:    taken = 1'b0;
			gcc_pkg::COND_ALWAYS:   taken = 1'b1;
			gcc_pkg::COND_NO_INPUT: taken = !in_valid;
			gcc_pkg::COND_DIV_BUSY: taken = status.div_busy;
			gcc_pkg::COND_OUT_FULL: taken = status.out_full;
			gcc_pkg::COND_MORE:     taken = status.more;
			default:                taken = 1'b1;
		endcase
	end

	assign step_d = taken ? ctl.target : gcc_pkg::step_t'(step_q + 3'd1);

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= gcc_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ----- sv/gcc_dpath.sv -----
// ----------------------------------------------------------------------------
// gcc_dpath
// Running remainder, bit-serial restoring divider, coin totals and the
// output register.
// ----------------------------------------------------------------------------
module gcc_dpath #(
	parameter int unsigned MAX_DENOMS  = 6,
	parameter int unsigned AMOUNT_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  gcc_pkg::ctl_word_t                       ctl,
	input  logic                                     in_valid,
	input  logic [15:0]                              pay_amount,
	input  logic [MAX_DENOMS-1:0][gcc_pkg::COIN_W-1:0] coin_values,
	input  logic [gcc_pkg::IDX_W-1:0]                denoms,
	input  logic                                     out_ready,
	output gcc_pkg::dp_status_t                      status,
	output logic                                     out_valid,
	output logic [gcc_pkg::IDX_W-1:0]                out_index,
	output logic [gcc_pkg::CNT_W-1:0]                out_count,
	output logic [gcc_pkg::CNT_W-1:0]                out_total,
	output logic                                     out_last
);

	localparam int unsigned AB   = AMOUNT_BITS;
	localparam int unsigned KW   = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
	localparam int unsigned CW   = $clog2(AB);
	localparam int unsigned CV_W = gcc_pkg::COIN_W;

	logic [AB-1:0]   rem_q;
	logic [AB-1:0]   total_q;
	logic [AB-1:0]   quo_q;
	logic [CV_W-1:0] part_q;
	logic [CW-1:0]   div_cnt_q;
	logic [KW-1:0]   k_q;

	logic                         out_valid_q;
	logic [gcc_pkg::IDX_W-1:0]    out_index_q;
	logic [gcc_pkg::CNT_W-1:0]    out_count_q;
	logic [gcc_pkg::CNT_W-1:0]    out_total_q;
	logic                         out_last_q;

	logic [gcc_pkg::IDX_W-1:0] n_eff;
	logic [KW-1:0]             k_start;
	logic [CV_W-1:0]           coin_v;
	logic                      coin_zero;
	logic [CV_W:0]             trial;
	logic                      ge;
	logic [CV_W-1:0]           part_d;
	logic [AB-1:0]             cnt;
	logic [AB-1:0]             total_d;
	logic [gcc_pkg::CNT_W-1:0] cnt_sat;
	logic [gcc_pkg::CNT_W-1:0] total_sat;
	logic                      ld_item;
	logic                      out_full;
	logic                      last_denom;

	// Clamp the denomination count to 1..MAX_DENOMS
	always_comb begin
		n_eff = denoms;
		if (denoms == '0) begin
			n_eff = gcc_pkg::IDX_W'(1);
		end else if (denoms > gcc_pkg::IDX_W'(MAX_DENOMS)) begin
			n_eff = gcc_pkg::IDX_W'(MAX_DENOMS);
		end
	end
	assign k_start = KW'(n_eff - gcc_pkg::IDX_W'(1));

	assign coin_v    = coin_values[k_q];
	assign coin_zero = (coin_v == '0);

	// One restoring division step: shift in the next dividend bit
	assign trial  = {part_q, quo_q[AB-1]};
	assign ge     = (trial >= {1'b0, coin_v});
	assign part_d = ge ? CV_W'(trial - {1'b0, coin_v}) : trial[CV_W-1:0];

	// A zero coin counts nothing and leaves the remainder alone
	assign cnt     = coin_zero ? '0 : quo_q;
	assign total_d = total_q + cnt;

	// Saturate counts to the output field
	if (AB > gcc_pkg::CNT_W) begin : g_sat
		assign cnt_sat   = (|cnt[AB-1:gcc_pkg::CNT_W]) ? '1 : cnt[gcc_pkg::CNT_W-1:0];
		assign total_sat = (|total_d[AB-1:gcc_pkg::CNT_W]) ? '1
			: total_d[gcc_pkg::CNT_W-1:0];
	end else begin : g_nosat
		assign cnt_sat   = gcc_pkg::CNT_W'(cnt);
		assign total_sat = gcc_pkg::CNT_W'(total_d);
	end

	assign ld_item    = ctl.in_ready && in_valid;
	assign out_full   = out_valid_q && !out_ready;
	assign last_denom = (k_q == '0);

	assign status.div_busy = (div_cnt_q != '0);
	assign status.out_full = out_full;
	assign status.more     = !last_denom;

	// Remainder, totals and denomination index
	always_ff @(posedge clk) begin
		if (ld_item) begin
			rem_q   <= AB'(pay_amount);
			total_q <= '0;
			k_q     <= k_start;
		end else if (ctl.emit) begin
			rem_q   <= coin_zero ? rem_q : AB'(part_q);
			total_q <= total_d;
			if (!last_denom) begin
				k_q <= k_q - KW'(1);
			end
		end
	end

	// Divider registers: load dividend, then one bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.div_init) begin
			quo_q     <= rem_q;
			part_q    <= '0;
			div_cnt_q <= CW'(AB - 1);
		end else if (ctl.div_step) begin
			quo_q  <= {quo_q[AB-2:0], ge};
			part_q <= part_d;
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - CW'(1);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_index_q <= gcc_pkg::IDX_W'(k_q);
			out_count_q <= cnt_sat;
			out_total_q <= last_denom ? total_sat : '0;
			out_last_q  <= last_denom;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_count = out_count_q;
	assign out_total = out_total_q;
	assign out_last  = out_last_q;

	// Never overwrite a beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !out_full)
		else $error("result written over a pending beat");

	// The last beat reports index 0
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_index_q == '0))
		else $error("last beat not at index 0");

	// Totals appear only on the last beat
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (out_total_q == '0))
		else $error("total on a beat that is not last");

	// Items are taken only while the divider is idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ld_item |-> (!ctl.div_step && !ctl.emit))
		else $error("item taken while busy");

endmodule

// ----- sv/greedy_coin_change_core.sv -----
// ----------------------------------------------------------------------------
// greedy_coin_change_core
// Greedy coin change: splits an amount into coins, largest denomination
// first, one result beat per denomination in use.
// ----------------------------------------------------------------------------
// An amount taken on the slave stream produces one beat per denomination in
// use, from the highest index down to index 0; the index-0 beat carries
// tlast and the total coin count. Each denomination costs one restoring
// division step per amount bit plus three control steps, one of which
// waits while the output register is still full. A new amount is taken
// while the final beat still waits in the output register. Write the
// coin registers only while the core is idle.
module greedy_coin_change_core #(
	parameter int unsigned MAX_DENOMS  = 6,
	parameter int unsigned AMOUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] pay_amount
	// master stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gcc_pkg::OUT_W-1:0]   m_tdata,   // [2:0] denom_index,
	                                               // [18:3] coin_count,
	                                               // [34:19] total_coins, zero fill
	output logic                        m_tlast,   // is_last
	// configuration
	input  logic                        cfg_we,
	input  logic [gcc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [gcc_pkg::COIN_W-1:0]  cfg_data
);

	logic [MAX_DENOMS-1:0][gcc_pkg::COIN_W-1:0] coin_value_q;
	logic [gcc_pkg::IDX_W-1:0]                   denoms_q;

	gcc_pkg::ctl_word_t  ctl;
	gcc_pkg::dp_status_t status;

	logic [gcc_pkg::IDX_W-1:0] out_index;
	logic [gcc_pkg::CNT_W-1:0] out_count;
	logic [gcc_pkg::CNT_W-1:0] out_total;

	// Coin value registers; indexes past MAX_DENOMS are dropped
	for (genvar i = 0; i < MAX_DENOMS; i++) begin : g_coin
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coin_value_q[i] <= gcc_pkg::COIN_RESET[i];
			end else if (cfg_we &&
				cfg_index == gcc_pkg::IDX_W'(gcc_pkg::REG_COIN_0 + i)) begin
				coin_value_q[i] <= cfg_data;
			end
		end
	end

	// Denomination count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denoms_q <= gcc_pkg::DENOMS_RESET;
		end else if (cfg_we && cfg_index == gcc_pkg::REG_DENOMS) begin
			denoms_q <= cfg_data[gcc_pkg::IDX_W-1:0];
		end
	end

	gcc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.ctl      (ctl)
	);

	gcc_dpath #(
		.MAX_DENOMS  (MAX_DENOMS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.in_valid    (s_tvalid),
		.pay_amount  (s_tdata),
		.coin_values (coin_value_q),
		.denoms      (denoms_q),
		.out_ready   (m_tready),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_index   (out_index),
		.out_count   (out_count),
		.out_total   (out_total),
		.out_last    (m_tlast)
	);

	assign s_tready = ctl.in_ready;
	assign m_tdata  = gcc_pkg::OUT_W'({out_total, out_count, out_index});

endmodule
